FILE: rtl/bqcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqcl_pkg;

  localparam int BAR_LEN_W = 24;
  localparam int BAR_CNT_W = 25;
  localparam int RAW_W     = 32;
  localparam int ROUND_W   = 33;
  localparam int NOTE_W    = 6;
  localparam int SLOT_W    = 4;

  localparam logic [BAR_LEN_W-1:0] BAR_LEN_RESET = 24'd96000;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic [1:0] PART_INTRO = 2'd0;
  localparam logic [1:0] PART_LOOP  = 2'd1;
  localparam logic [1:0] PART_OUTRO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_DIV,
    ST_LOAD_WR,
    ST_BAR_DIV,
    ST_CLIP_CHK,
    ST_CLIP_DIV,
    ST_EMIT
  } state_t;

  // what a clip wrap sends out
  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_FIRST,
    PLAN_LOOP,
    PLAN_OUTRO
  } plan_t;

  function automatic logic [7:0] slot_entry(input logic [SLOT_W-1:0] slot,
                                            input logic [1:0] part);
    slot_entry = ({4'd0, slot} * 8'd3) + {6'd0, part};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bqcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bqcl_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bqcl_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module bqcl_mod #(
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("remainder done without a finished run");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (dvs_r != '0) |-> rem_r < dvs_r)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

FILE: rtl/bar_quantized_clip_launcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Clip launcher on a bar grid. A load word (tuser high) rounds its raw length to the nearest
// multiple of bar_length, ties upward, and appends it to a length table of three entries per
// slot (intro, loop, outro); loads past the table's end are dropped. A tick word (tuser low)
// advances the bar and clip counters; when both wrap, the selected and previous slots decide
// up to three note on/off words, the last flagged by out_tlast. A tick that wraps nothing is
// handled in idle; every remainder goes through one shared bit-serial unit that settles one
// quotient bit per cycle. A load runs a remainder, then writes the table; a bar wrap runs a
// remainder, then checks the clip counter; a clip wrap runs another and sends its note words,
// one per cycle while the output is taken. The length table is a one-port-write,
// registered-read memory with no clearing pass; entries read before being loaded are undefined.
module bar_quantized_clip_launcher #(
  parameter int NUM_SLOTS   = 16,
  parameter int LENGTH_BITS = 33
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,  // bar_length
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,     // slot_selected, slot_index[3:0], raw_length[31:0], pad
  input  wire logic        in_tuser,     // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,    // note_on, note_number[5:0], pad
  output logic             out_tlast
);

  localparam int TABLE_DEPTH = 3 * NUM_SLOTS;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int LCW         = $clog2(TABLE_DEPTH + 1);
  localparam int DW          = (LENGTH_BITS > bqcl_pkg::RAW_W) ? LENGTH_BITS : bqcl_pkg::RAW_W;

  bqcl_pkg::state_t state_r, state_nxt;
  bqcl_pkg::plan_t  plan_r, plan_nxt;

  logic [bqcl_pkg::BAR_LEN_W-1:0] bar_length_r, bar_length_nxt;
  logic [LCW-1:0]                 load_count_r, load_count_nxt;
  logic [bqcl_pkg::BAR_CNT_W-1:0] bar_count_r, bar_count_nxt;
  logic [LENGTH_BITS-1:0]         clip_count_r, clip_count_nxt;
  logic [LENGTH_BITS-1:0]         cur_len_r, cur_len_nxt;
  logic                           prev_valid_r, prev_valid_nxt;
  logic [bqcl_pkg::SLOT_W-1:0]    prev_slot_r, prev_slot_nxt;
  logic                           first_play_r, first_play_nxt;

  logic                           sel_r, sel_nxt;
  logic [bqcl_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [bqcl_pkg::RAW_W-1:0]     raw_r, raw_nxt;
  logic [bqcl_pkg::SLOT_W-1:0]    ev_slot_r, ev_slot_nxt;
  logic [1:0]                     ev_idx_r, ev_idx_nxt;
  logic [bqcl_pkg::ROUND_W-1:0]   len_down_r, len_down_nxt;
  logic                           rnd_up_r, rnd_up_nxt;

  logic                           out_tvalid_r, out_tvalid_nxt;
  logic                           out_on_r, out_on_nxt;
  logic [bqcl_pkg::NOTE_W-1:0]    out_note_r, out_note_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           in_acc;
  logic                           div_start;
  logic [DW-1:0]                  div_dividend;
  logic [DW-1:0]                  div_divisor;
  logic                           div_done;
  logic [DW-1:0]                  div_rem;

  logic                           ram_wr_en;
  logic [AW-1:0]                  ram_wr_addr;
  logic [LENGTH_BITS-1:0]         ram_wr_data;
  logic                           ram_rd_en;
  logic [AW-1:0]                  ram_rd_addr;
  logic [LENGTH_BITS-1:0]         ram_rd_data;

  logic [bqcl_pkg::BAR_LEN_W-1:0] rnd_m;
  logic [bqcl_pkg::ROUND_W-1:0]   len_full;
  logic [LENGTH_BITS-1:0]         clip_mod;
  logic                           ev_on;
  logic [1:0]                     ev_part;
  logic                           ev_last;

  assign in_acc = in_tvalid && in_tready;

  bqcl_mod #(
    .DW(DW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  bqcl_ram #(
    .WIDTH(LENGTH_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // note word for the current step of the plan
  always_comb begin
    ev_on   = 1'b0;
    ev_part = bqcl_pkg::PART_INTRO;
    ev_last = 1'b1;
    case (plan_r)
      bqcl_pkg::PLAN_FIRST: begin
        ev_on = 1'b1;
      end
      bqcl_pkg::PLAN_LOOP: begin
        ev_part = bqcl_pkg::PART_LOOP;
        ev_on   = (ev_idx_r == 2'd1);
        ev_last = (ev_idx_r == 2'd1);
      end
      bqcl_pkg::PLAN_OUTRO: begin
        ev_last = (ev_idx_r == 2'd2);
        ev_on   = (ev_idx_r == 2'd2);
        if (ev_idx_r == 2'd0) begin
          ev_part = bqcl_pkg::PART_INTRO;
        end else if (ev_idx_r == 2'd1) begin
          ev_part = bqcl_pkg::PART_LOOP;
        end else begin
          ev_part = bqcl_pkg::PART_OUTRO;
        end
      end
      default: begin
        ev_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    plan_nxt       = plan_r;
    bar_length_nxt = bar_length_r;
    load_count_nxt = load_count_r;
    bar_count_nxt  = bar_count_r;
    clip_count_nxt = clip_count_r;
    cur_len_nxt    = cur_len_r;
    prev_valid_nxt = prev_valid_r;
    prev_slot_nxt  = prev_slot_r;
    first_play_nxt = first_play_r;
    sel_nxt        = sel_r;
    slot_nxt       = slot_r;
    raw_nxt        = raw_r;
    ev_slot_nxt    = ev_slot_r;
    ev_idx_nxt     = ev_idx_r;
    len_down_nxt   = len_down_r;
    rnd_up_nxt     = rnd_up_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_on_nxt     = out_on_r;
    out_note_nxt   = out_note_r;
    out_last_nxt   = out_last_r;

    div_start      = 1'b0;
    div_dividend   = DW'(bar_count_r);
    div_divisor    = DW'(bar_length_r);
    ram_wr_en      = 1'b0;
    ram_wr_addr    = AW'(load_count_r);
    ram_rd_en      = 1'b0;
    ram_rd_addr    = AW'(bqcl_pkg::slot_entry(slot_r, bqcl_pkg::PART_INTRO));

    rnd_m          = div_rem[bqcl_pkg::BAR_LEN_W-1:0];
    len_full       = len_down_r + (rnd_up_r ? {9'd0, bar_length_r} : '0);
    ram_wr_data    = LENGTH_BITS'(len_full);
    clip_mod       = (cur_len_r == '0) ? '0 : LENGTH_BITS'(div_rem);

    if (cfg_wr_en) begin
      bar_length_nxt = cfg_wr_data;
    end

    unique case (state_r)
      bqcl_pkg::ST_IDLE: begin
        if (in_acc) begin
          sel_nxt  = in_tdata[0] && ({28'd0, in_tdata[4:1]} < 32'(NUM_SLOTS));
          slot_nxt = in_tdata[4:1];
          raw_nxt  = in_tdata[36:5];
          if (in_tuser == bqcl_pkg::ACT_LOAD) begin
            div_start    = 1'b1;
            div_dividend = DW'(in_tdata[36:5]);
            state_nxt    = bqcl_pkg::ST_LOAD_DIV;
          end else if (bar_count_r > {1'b0, bar_length_r}) begin
            div_start = 1'b1;
            state_nxt = bqcl_pkg::ST_BAR_DIV;
          end else begin
            bar_count_nxt  = bar_count_r + bqcl_pkg::BAR_CNT_W'(1);
            clip_count_nxt = clip_count_r + LENGTH_BITS'(1);
          end
        end
      end
      bqcl_pkg::ST_LOAD_DIV: begin
        if (div_done) begin
          if (bar_length_r == '0) begin
            len_down_nxt = {1'b0, raw_r};
            rnd_up_nxt   = 1'b0;
          end else begin
            len_down_nxt = {1'b0, raw_r} - {9'd0, rnd_m};
            rnd_up_nxt   = ({rnd_m, 1'b0} >= {1'b0, bar_length_r});
          end
          state_nxt = bqcl_pkg::ST_LOAD_WR;
        end
      end
      bqcl_pkg::ST_LOAD_WR: begin
        if (load_count_r < LCW'(TABLE_DEPTH)) begin
          ram_wr_en      = 1'b1;
          load_count_nxt = load_count_r + LCW'(1);
        end
        state_nxt = bqcl_pkg::ST_IDLE;
      end
      bqcl_pkg::ST_BAR_DIV: begin
        if (div_done) begin
          bar_count_nxt = (bar_length_r == '0) ? '0 : bqcl_pkg::BAR_CNT_W'(div_rem);
          state_nxt     = bqcl_pkg::ST_CLIP_CHK;
        end
      end
      bqcl_pkg::ST_CLIP_CHK: begin
        if (clip_count_r > cur_len_r) begin
          div_start    = 1'b1;
          div_dividend = DW'(clip_count_r);
          div_divisor  = DW'(cur_len_r);
          ram_rd_en    = 1'b1;
          ev_idx_nxt   = 2'd0;
          ev_slot_nxt  = slot_r;
          if (sel_r) begin
            if (prev_valid_r && (slot_r == prev_slot_r)) begin
              if (first_play_r) begin
                plan_nxt       = bqcl_pkg::PLAN_FIRST;
                first_play_nxt = 1'b0;
              end else begin
                plan_nxt    = bqcl_pkg::PLAN_LOOP;
                ram_rd_addr = AW'(bqcl_pkg::slot_entry(slot_r, bqcl_pkg::PART_LOOP));
              end
            end else if (prev_valid_r) begin
              plan_nxt       = bqcl_pkg::PLAN_OUTRO;
              ev_slot_nxt    = prev_slot_r;
              ram_rd_addr    = AW'(bqcl_pkg::slot_entry(prev_slot_r, bqcl_pkg::PART_OUTRO));
              first_play_nxt = 1'b1;
            end else begin
              plan_nxt       = bqcl_pkg::PLAN_FIRST;
              first_play_nxt = 1'b0;
            end
            prev_slot_nxt  = slot_r;
            prev_valid_nxt = 1'b1;
          end else begin
            if (prev_valid_r) begin
              plan_nxt    = bqcl_pkg::PLAN_OUTRO;
              ev_slot_nxt = prev_slot_r;
              ram_rd_addr = AW'(bqcl_pkg::slot_entry(prev_slot_r, bqcl_pkg::PART_OUTRO));
            end else begin
              plan_nxt  = bqcl_pkg::PLAN_NONE;
              ram_rd_en = 1'b0;
            end
            prev_valid_nxt = 1'b0;
          end
          state_nxt = bqcl_pkg::ST_CLIP_DIV;
        end else begin
          bar_count_nxt  = bar_count_r + bqcl_pkg::BAR_CNT_W'(1);
          clip_count_nxt = clip_count_r + LENGTH_BITS'(1);
          state_nxt      = bqcl_pkg::ST_IDLE;
        end
      end
      bqcl_pkg::ST_CLIP_DIV: begin
        if (div_done) begin
          clip_count_nxt = clip_mod + LENGTH_BITS'(1);
          bar_count_nxt  = bar_count_r + bqcl_pkg::BAR_CNT_W'(1);
          cur_len_nxt    = (plan_r == bqcl_pkg::PLAN_NONE) ?
                           LENGTH_BITS'(bar_length_r) : ram_rd_data;
          state_nxt      = (plan_r == bqcl_pkg::PLAN_NONE) ?
                           bqcl_pkg::ST_IDLE : bqcl_pkg::ST_EMIT;
        end
      end
      bqcl_pkg::ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_on_nxt     = ev_on;
          out_note_nxt   = bqcl_pkg::NOTE_W'(bqcl_pkg::slot_entry(ev_slot_r, ev_part));
          out_last_nxt   = ev_last;
          if (ev_last) begin
            state_nxt = bqcl_pkg::ST_IDLE;
          end else begin
            ev_idx_nxt = ev_idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = bqcl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bqcl_pkg::ST_IDLE;
      bar_length_r <= bqcl_pkg::BAR_LEN_RESET;
      load_count_r <= '0;
      bar_count_r  <= '0;
      clip_count_r <= '0;
      cur_len_r    <= '0;
      prev_valid_r <= 1'b0;
      prev_slot_r  <= '0;
      first_play_r <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bar_length_r <= bar_length_nxt;
      load_count_r <= load_count_nxt;
      bar_count_r  <= bar_count_nxt;
      clip_count_r <= clip_count_nxt;
      cur_len_r    <= cur_len_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_slot_r  <= prev_slot_nxt;
      first_play_r <= first_play_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    plan_r     <= plan_nxt;
    sel_r      <= sel_nxt;
    slot_r     <= slot_nxt;
    raw_r      <= raw_nxt;
    ev_slot_r  <= ev_slot_nxt;
    ev_idx_r   <= ev_idx_nxt;
    len_down_r <= len_down_nxt;
    rnd_up_r   <= rnd_up_nxt;
    out_on_r   <= out_on_nxt;
    out_note_r <= out_note_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == bqcl_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_note_r, out_on_r};
  assign out_tlast  = out_last_r;

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= LCW'(TABLE_DEPTH))
    else $error("load count past table depth");

  a_emit_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bqcl_pkg::ST_EMIT) |-> (plan_r != bqcl_pkg::PLAN_NONE))
    else $error("emitting with no note plan");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == bqcl_pkg::ST_LOAD_DIV || state_r == bqcl_pkg::ST_BAR_DIV ||
                  state_r == bqcl_pkg::ST_CLIP_DIV))
    else $error("remainder finished with no waiting state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bqcl_pkg::ST_EMIT) && (!out_tvalid_r || out_tready) && ev_last
    |=> (state_r == bqcl_pkg::ST_IDLE) && out_tvalid_r && out_tlast)
    else $error("final note word not followed by idle");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int TAB_DEPTH = 48;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                          act;
    logic                          sel;
    logic [bqcl_pkg::SLOT_W-1:0]   slot;
    logic [bqcl_pkg::RAW_W-1:0]    raw;
  } launch_word_t;

  typedef struct packed {
    logic                        on;
    logic [bqcl_pkg::NOTE_W-1:0] note;
    logic                        last;
  } note_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [bqcl_pkg::BAR_LEN_W-1:0] cfg_wr_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [39:0]                    in_tdata = '0;   // slot_selected, slot_index[3:0], raw_length[31:0], pad
  logic                           in_tuser = 1'b0; // action
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;       // note_on, note_number[5:0], pad
  logic                           out_tlast;

  bar_quantized_clip_launcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // launcher state as the predictor sees it
  logic [bqcl_pkg::BAR_LEN_W-1:0] bar_len = bqcl_pkg::BAR_LEN_RESET;
  logic [bqcl_pkg::ROUND_W-1:0]   len_tab [TAB_DEPTH];
  logic [5:0]                     loads_done = '0;
  logic [bqcl_pkg::BAR_CNT_W-1:0] bar_cnt = '0;
  logic [bqcl_pkg::ROUND_W-1:0]   clip_cnt = '0;
  logic [bqcl_pkg::ROUND_W-1:0]   cur_len = '0;
  logic                           prev_ok = 1'b0;
  logic [bqcl_pkg::SLOT_W-1:0]    prev_slot = '0;
  logic                           first_up = 1'b1;

  launch_word_t pending[$];
  note_word_t   notes_due[$];
  launch_word_t offered;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_queued = 0;
  int words_taken = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int notes_seen = 0;
  int notes_on_seen = 0;
  int bar_settings = 0;
  int mismatches = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [bqcl_pkg::NOTE_W-1:0] note_of(
      input logic [bqcl_pkg::SLOT_W-1:0] s, input logic [1:0] part);
    return bqcl_pkg::NOTE_W'(int'(s) * 3 + int'(part));
  endfunction

  task automatic queue_note(input logic on, input logic [bqcl_pkg::NOTE_W-1:0] nn);
    note_word_t nw;
    nw.on = on;
    nw.note = nn;
    nw.last = 1'b0;
    notes_due.insert(notes_due.size(), nw);
  endtask

  task automatic queue_outro();
    queue_note(1'b0, note_of(prev_slot, bqcl_pkg::PART_INTRO));
    queue_note(1'b0, note_of(prev_slot, bqcl_pkg::PART_LOOP));
    queue_note(1'b1, note_of(prev_slot, bqcl_pkg::PART_OUTRO));
    cur_len = len_tab[note_of(prev_slot, bqcl_pkg::PART_OUTRO)];
  endtask

  task automatic predict_notes(input launch_word_t w);
    logic [63:0] rem;
    logic [63:0] len;
    int n0;
    n0 = notes_due.size();
    if (w.act == bqcl_pkg::ACT_LOAD) begin
      len = {32'd0, w.raw};
      if (bar_len != 0) begin
        rem = len % bar_len;
        if (2 * rem < bar_len) begin
          len = len - rem;
        end else begin
          len = len + (bar_len - rem);
        end
      end
      if (loads_done < TAB_DEPTH) begin
        len_tab[loads_done] = len[bqcl_pkg::ROUND_W-1:0];
        loads_done++;
      end
    end else begin
      if (bar_cnt > bar_len) begin
        bar_cnt = (bar_len != 0) ? bar_cnt % bar_len : '0;
        if (clip_cnt > cur_len) begin
          clip_cnt = (cur_len != 0) ? clip_cnt % cur_len : '0;
          if (w.sel) begin
            if (prev_ok && w.slot == prev_slot) begin
              if (first_up) begin
                queue_note(1'b1, note_of(w.slot, bqcl_pkg::PART_INTRO));
                cur_len = len_tab[note_of(w.slot, bqcl_pkg::PART_INTRO)];
                first_up = 1'b0;
              end else begin
                queue_note(1'b0, note_of(w.slot, bqcl_pkg::PART_LOOP));
                queue_note(1'b1, note_of(w.slot, bqcl_pkg::PART_LOOP));
                cur_len = len_tab[note_of(w.slot, bqcl_pkg::PART_LOOP)];
              end
            end else if (prev_ok) begin
              queue_outro();
              first_up = 1'b1;
            end else begin
              queue_note(1'b1, note_of(w.slot, bqcl_pkg::PART_INTRO));
              cur_len = len_tab[note_of(w.slot, bqcl_pkg::PART_INTRO)];
              first_up = 1'b0;
            end
            prev_slot = w.slot;
            prev_ok = 1'b1;
          end else begin
            if (prev_ok) begin
              queue_outro();
            end else begin
              cur_len = bqcl_pkg::ROUND_W'(bar_len);
            end
            prev_ok = 1'b0;
          end
        end
      end
      bar_cnt = bar_cnt + 1'b1;
      clip_cnt = clip_cnt + 1'b1;
      if (notes_due.size() > n0) begin
        notes_due[notes_due.size()-1].last = 1'b1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_notes(offered);
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b000, offered.raw, offered.slot, offered.sel};
          in_tuser <= offered.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    note_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        notes_seen++;
        if (out_tdata[0]) begin
          notes_on_seen++;
        end
        if (notes_due.size() == 0) begin
          flag_mismatch($sformatf("note word %h with nothing pending", out_tdata));
        end else begin
          want = notes_due.pop_front();
          if (out_tdata[0] !== want.on) begin
            flag_mismatch($sformatf("note_on %b, want %b", out_tdata[0], want.on));
          end
          if (out_tdata[6:1] !== want.note) begin
            flag_mismatch($sformatf("note_number %0d, want %0d", out_tdata[6:1], want.note));
          end
          if (out_tlast !== want.last) begin
            flag_mismatch($sformatf("tlast %b, want %b", out_tlast, want.last));
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input logic act, input logic sel,
                           input logic [bqcl_pkg::SLOT_W-1:0] slot,
                           input logic [bqcl_pkg::RAW_W-1:0] raw);
    launch_word_t lw;
    lw.act = act;
    lw.sel = sel;
    lw.slot = slot;
    lw.raw = raw;
    pending.insert(pending.size(), lw);
    words_queued++;
    if (act == bqcl_pkg::ACT_LOAD) begin
      loads_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic push_load(input logic [bqcl_pkg::RAW_W-1:0] raw);
    push_word(bqcl_pkg::ACT_LOAD, 1'($urandom()), bqcl_pkg::SLOT_W'($urandom()), raw);
  endtask

  task automatic push_tick(input logic sel, input logic [bqcl_pkg::SLOT_W-1:0] slot);
    push_word(bqcl_pkg::ACT_TICK, sel, slot, $urandom());
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || notes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_bar(input logic [bqcl_pkg::BAR_LEN_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bar_len = v;
    bar_settings++;
  endtask

  // slot 0 holds the oversized lengths and is kept out of normal play
  task automatic play(input int n, input logic [bqcl_pkg::BAR_LEN_W-1:0] b, input bit hold);
    int run_left;
    logic pick_on;
    logic [bqcl_pkg::SLOT_W-1:0] pick_slot;
    run_left = 0;
    pick_on = 1'b0;
    pick_slot = 4'd1;
    set_bar(b);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (hold) begin
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        wait_drained();
      end
      if ($urandom_range(9) == 0) begin
        push_load($urandom());
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(40, 4);
          pick_on = ($urandom_range(4) != 0);
          pick_slot = bqcl_pkg::SLOT_W'($urandom_range(15, 1));
        end
        run_left--;
        push_tick(pick_on, pick_on ? pick_slot : bqcl_pkg::SLOT_W'($urandom()));
      end
    end
  endtask

  initial begin
    int b;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // slot 0: widest rounding cases
    set_bar(24'hFFFFFF);
    push_load(32'hFFFF_FFFF);
    push_load(32'd8388608);
    push_tick(1'b1, 4'hF);
    push_tick(1'b0, 4'h0);
    set_bar(24'd2);
    push_load(32'hFFFF_FFFF);
    // ties and near ties on a grid of four, one zero length
    set_bar(24'd4);
    push_load(32'd2);
    push_load(32'd5);
    push_load(32'd6);
    push_load(32'd9);
    push_load(32'd0);
    push_load(32'd10);
    set_bar(24'd1);
    push_load(32'd7);
    push_load(32'd1);
    push_load(32'd3);
    push_tick(1'b0, 4'h5);
    push_tick(1'b0, 4'hA);
    push_tick(1'b0, 4'h3);

    // fill the rest of the table, no slot selected yet
    send_idle_pct = 16;
    recv_stall_pct = 16;
    while (loads_sent < TAB_DEPTH) begin
      b = $urandom_range(6, 1);
      set_bar(bqcl_pkg::BAR_LEN_W'(b));
      for (int i = 0; i < 12 && loads_sent < TAB_DEPTH; i++) begin
        push_load($urandom_range(4 * b));
        if ($urandom_range(1) != 0) begin
          push_tick(1'b0, bqcl_pkg::SLOT_W'($urandom()));
        end
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    play(70, 24'd1, 1'b1);
    send_idle_pct = 83;
    recv_stall_pct = 0;
    play(70, 24'd2, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    play(70, 24'd3, 1'b0);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    play(70, 24'd1, 1'b0);
    wait_drained();
    while (notes_seen < 60) begin
      play(40, bqcl_pkg::BAR_LEN_W'($urandom_range(3, 1)), 1'b0);
      wait_drained();
    end

    // release everything, then launch slot 0 once
    set_bar(24'd1);
    repeat (80) push_tick(1'b0, bqcl_pkg::SLOT_W'($urandom()));
    repeat (10) push_tick(1'b1, 4'd0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d loads and %0d ticks over %0d bar length settings, 1 up to %0d samples",
             loads_sent, ticks_sent, bar_settings, 24'hFFFFFF);
    $display("%0d note words checked, %0d of them note on", notes_seen, notes_on_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
